// ----- hdl/sdcd_pkg.sv -----
package sdcd_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [22:0] MAG_MAX = 23'd8388607;

    typedef enum logic [1:0] {
        KIND_BYTE, KIND_STATUS, KIND_LINK, KIND_SPARE
    } t_kind;

    typedef enum logic [2:0] {
        ACT_REPORT  = 3'd0,
        ACT_SETVEL  = 3'd1,
        ACT_ENABLE  = 3'd2,
        ACT_DISABLE = 3'd3,
        ACT_RESET   = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_BAD_LETTER = 4'd1,
        ST_BAD_PARAMS = 4'd2,
        ST_BAD_MOTOR  = 4'd3,
        ST_UNKNOWN    = 4'd4,
        ST_OVERRUN    = 4'd5,
        ST_LIMIT      = 4'd6,
        ST_ALERT      = 4'd7,
        ST_UNEXP_DIS  = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        REG_MAX_SPEED, REG_DIR_INV, REG_HALF_TRACK, REG_RPM_GAIN
    } t_reg;

    typedef enum logic [1:0] {CLS_NONE, CLS_ONE, CLS_VEL} t_cls;

    typedef enum logic [2:0] {K_HOLD, K_TERM, K_SUM, K_MUL, K_MAG, K_ZERO} t_kstep;

    typedef enum logic [1:0] {OSEL_CODE, OSEL_LINE, OSEL_WHEEL} t_osel;

    typedef struct packed {
        logic [14:0] max_speed;
        logic [3:0]  dir_inv;
        logic [17:0] half_track;
        logic [23:0] rpm_gain;
    } t_cfg;

    typedef struct packed {
        logic     take;
        logic     clear;
        t_kstep   kstep;
        logic     plus;
        logic     div_start;
        logic     load;
        t_osel    osel;
        logic [1:0] motor;
        t_action  act;
        t_status  st;
        logic     last;
    } t_cmd;

    typedef struct packed {
        t_cls       cls;
        logic       div_done;
        logic [3:0] en;
    } t_sts;

    typedef struct packed {
        logic [1:0]  motor_index;
        t_action     action;
        logic        direction_level;
        logic [7:0]  duty;
        logic [15:0] velocity;
        t_status     status;
        logic        last;
    } t_res;

endpackage

// ----- hdl/sdcd_if.sv -----
interface sdcd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [3:0] alert_flags;
    logic [3:0] enabled_flags;

    modport source (output valid, kind, rx_byte, alert_flags, enabled_flags,
                    input ready);
    modport sink (input valid, kind, rx_byte, alert_flags, enabled_flags,
                  output ready);
endinterface

interface sdcd_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        motor_index;
    logic [2:0]        action;
    logic              direction_level;
    logic [7:0]        duty;
    logic signed [15:0] velocity;
    logic [3:0]        status;
    logic              last;

    modport source (output valid, motor_index, action, direction_level, duty,
                    velocity, status, last, input ready);
    modport sink (input valid, motor_index, action, direction_level, duty,
                  velocity, status, last, output ready);
endinterface

// ----- hdl/sdcd_cfg.sv -----
module sdcd_cfg
    import sdcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_reg reg_sel;

    assign reg_sel = t_reg'(paddr[3:2]);
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed  <= 15'd1000;
            r_cfg.dir_inv    <= 4'd3;
            r_cfg.half_track <= 18'd19661;
            r_cfg.rpm_gain   <= 24'd4172;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_MAX_SPEED:  r_cfg.max_speed  <= pwdata[14:0];
                REG_DIR_INV:    r_cfg.dir_inv    <= pwdata[3:0];
                REG_HALF_TRACK: r_cfg.half_track <= pwdata[17:0];
                REG_RPM_GAIN:   r_cfg.rpm_gain   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_MAX_SPEED:  prdata = {17'd0, r_cfg.max_speed};
            REG_DIR_INV:    prdata = {28'd0, r_cfg.dir_inv};
            REG_HALF_TRACK: prdata = {14'd0, r_cfg.half_track};
            REG_RPM_GAIN:   prdata = {8'd0, r_cfg.rpm_gain};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

// ----- hdl/sdcd_dp.sv -----
module sdcd_dp
    import sdcd_pkg::*;
#(
    parameter int LINE_LIMIT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_cmd       i_cmd,
    input  t_kind      i_kind,
    input  logic [7:0] i_rx_byte,
    input  logic [3:0] i_alert_flags,
    input  logic [3:0] i_enabled_flags,
    output t_sts       o_sts,
    output t_res       o_res
);

    localparam int LW = $clog2(LINE_LIMIT + 1);

    typedef enum logic [3:0] {
        PH_IDLE, PH_V_WS1, PH_V_SIGN1, PH_V_DIG1, PH_V_WS2, PH_V_SIGN2,
        PH_V_DIG2, PH_DONE, PH_FAIL, PH_M_FIRST, PH_M_DIG
    } t_phase;

    function automatic logic [22:0] f_acc(input logic [22:0] v, input logic [3:0] d);
        logic [26:0] n;
        n = {4'd0, v} * 27'd10 + {23'd0, d};
        return (v > 23'd838860 || n > {4'd0, MAG_MAX}) ? MAG_MAX : n[22:0];
    endfunction

    // line parser
    logic [LW-1:0] r_len, n_len;
    logic          r_ovr, n_ovr;
    logic [7:0]    r_letter, n_letter;
    t_phase        r_phase, n_phase;
    logic [2:0]    r_mn, n_mn;
    logic [22:0]   r_lin, n_lin, r_ang, n_ang;
    logic          r_neg1, n_neg1, r_neg2, n_neg2;
    logic [3:0]    r_alert, r_en;
    t_cls          r_cls, n_cls;
    logic [1:0]    r_cls_motor, n_cls_motor;
    t_action       r_cls_act, n_cls_act;
    t_status       r_cls_st, n_cls_st;

    logic [7:0] c, fold;
    logic       c_dig, c_blank, c_sign, rp_done;
    logic [3:0] dig;
    logic [5:0] mn_n;

    assign c       = i_rx_byte;
    assign fold    = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    assign c_dig   = c >= 8'd48 && c <= 8'd57;
    assign c_blank = c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    assign c_sign  = c == 8'd43 || c == 8'd45;
    assign dig     = c[3:0];
    assign mn_n    = {3'd0, r_mn} * 6'd10 + {2'd0, dig};
    assign rp_done = r_phase == PH_V_DIG2 || r_phase == PH_M_DIG || r_phase == PH_DONE;

    always_comb begin
        n_len = r_len; n_ovr = r_ovr; n_letter = r_letter; n_phase = r_phase;
        n_mn = r_mn; n_lin = r_lin; n_ang = r_ang; n_neg1 = r_neg1; n_neg2 = r_neg2;
        n_cls = r_cls; n_cls_motor = r_cls_motor; n_cls_act = r_cls_act;
        n_cls_st = r_cls_st;
        if (i_cmd.clear) begin
            n_len = '0; n_ovr = 1'b0; n_letter = 8'd0; n_phase = PH_IDLE;
            n_mn = 3'd0; n_lin = 23'd0; n_ang = 23'd0; n_neg1 = 1'b0; n_neg2 = 1'b0;
        end else if (i_cmd.take && i_kind == KIND_BYTE && c != CH_CR) begin
            if (c == CH_LF) begin
                // classify the finished line
                n_cls_motor = 2'd0;
                n_cls_act   = ACT_REPORT;
                n_cls_st    = ST_OK;
                n_cls       = CLS_ONE;
                if (r_ovr) begin
                    n_cls_st = ST_OVERRUN;
                end else if (r_len == '0) begin
                    n_cls = CLS_NONE;
                end else if (r_letter < 8'd97 || r_letter > 8'd122) begin
                    n_cls_st = ST_BAD_LETTER;
                end else if (r_letter == 8'd118) begin
                    if (rp_done) n_cls = CLS_VEL;
                    else n_cls_st = ST_BAD_PARAMS;
                end else if (!rp_done || r_mn > 3'd3) begin
                    n_cls_st = ST_BAD_MOTOR;
                end else if (r_letter == 8'd100) begin
                    n_cls_motor = r_mn[1:0];
                    n_cls_act   = ACT_DISABLE;
                end else if (r_letter == 8'd101) begin
                    n_cls_motor = r_mn[1:0];
                    n_cls_act   = ACT_ENABLE;
                end else begin
                    n_cls_st = ST_UNKNOWN;
                end
            end else if (r_len < LW'(LINE_LIMIT)) begin
                n_len = r_len + LW'(1);
                if (r_len == '0) begin
                    n_letter = fold;
                    n_phase  = (c == 8'd0) ? PH_FAIL
                             : (fold == 8'd118 ? PH_V_WS1 : PH_M_FIRST);
                end else if (r_phase != PH_DONE && r_phase != PH_FAIL
                             && r_phase != PH_IDLE) begin
                    if (c == 8'd0) begin
                        n_phase = rp_done ? PH_DONE : PH_FAIL;
                    end else begin
                        case (r_phase)
                            PH_V_WS1, PH_V_WS2: begin
                                if (c_blank) begin
                                    n_phase = r_phase;
                                end else if (c_sign) begin
                                    if (c == 8'd45) begin
                                        if (r_phase == PH_V_WS2) n_neg2 = 1'b1;
                                        else n_neg1 = 1'b1;
                                    end
                                    n_phase = (r_phase == PH_V_WS2) ? PH_V_SIGN2 : PH_V_SIGN1;
                                end else if (c_dig) begin
                                    if (r_phase == PH_V_WS2) begin
                                        n_ang = f_acc(r_ang, dig); n_phase = PH_V_DIG2;
                                    end else begin
                                        n_lin = f_acc(r_lin, dig); n_phase = PH_V_DIG1;
                                    end
                                end else begin
                                    n_phase = PH_FAIL;
                                end
                            end
                            PH_V_SIGN1: begin
                                if (c_dig) begin
                                    n_lin = f_acc(r_lin, dig); n_phase = PH_V_DIG1;
                                end else n_phase = PH_FAIL;
                            end
                            PH_V_SIGN2: begin
                                if (c_dig) begin
                                    n_ang = f_acc(r_ang, dig); n_phase = PH_V_DIG2;
                                end else n_phase = PH_FAIL;
                            end
                            PH_V_DIG1: begin
                                if (c_dig) n_lin = f_acc(r_lin, dig);
                                else if (c_blank) n_phase = PH_V_WS2;
                                else if (c_sign) begin
                                    if (c == 8'd45) n_neg2 = 1'b1;
                                    n_phase = PH_V_SIGN2;
                                end else n_phase = PH_FAIL;
                            end
                            PH_V_DIG2: begin
                                if (c_dig) n_ang = f_acc(r_ang, dig);
                                else n_phase = PH_DONE;
                            end
                            PH_M_FIRST, PH_M_DIG: begin
                                if (c_dig) begin
                                    n_mn = (r_mn > 3'd3 || mn_n > 6'd3) ? 3'd4 : mn_n[2:0];
                                    n_phase = PH_M_DIG;
                                end else begin
                                    n_phase = (r_phase == PH_M_DIG) ? PH_DONE : PH_FAIL;
                                end
                            end
                            default: n_phase = PH_FAIL;
                        endcase
                    end
                end
            end else begin
                n_ovr = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0; r_ovr <= 1'b0; r_letter <= 8'd0; r_phase <= PH_IDLE;
            r_mn <= 3'd0; r_lin <= 23'd0; r_ang <= 23'd0;
            r_neg1 <= 1'b0; r_neg2 <= 1'b0;
            r_alert <= 4'd0; r_en <= 4'hF;
            r_cls <= CLS_NONE;
        end else begin
            r_len <= n_len; r_ovr <= n_ovr; r_letter <= n_letter; r_phase <= n_phase;
            r_mn <= n_mn; r_lin <= n_lin; r_ang <= n_ang;
            r_neg1 <= n_neg1; r_neg2 <= n_neg2;
            r_cls <= n_cls;
            if (i_cmd.take && i_kind == KIND_STATUS) begin
                r_alert <= i_alert_flags;
                r_en    <= i_enabled_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls_motor <= n_cls_motor;
        r_cls_act   <= n_cls_act;
        r_cls_st    <= n_cls_st;
    end

    // kinematics, one multiply level per step
    logic signed [23:0] ang_c;
    logic [23:0]        lin_c;
    logic signed [42:0] r_term;
    logic [43:0]        lin_x, term_x, d_sum, d_abs;
    logic [41:0]        r_dm;
    logic               r_dneg, r_neg;
    logic [53:0]        r_p1, r_p2;
    logic [54:0]        t_sum;
    logic [34:0]        mag, r_mag;

    assign ang_c  = r_neg2 ? -$signed({1'b0, r_ang}) : $signed({1'b0, r_ang});
    assign lin_c  = r_neg1 ? 24'd0 - {1'b0, r_lin} : {1'b0, r_lin};
    assign lin_x  = {{4{lin_c[23]}}, lin_c, 16'd0};
    assign term_x = {r_term[42], r_term};
    assign d_sum  = i_cmd.plus ? lin_x + term_x : lin_x - term_x;
    assign d_abs  = d_sum[43] ? 44'd0 - d_sum : d_sum;
    assign t_sum  = {1'b0, r_p1} + {13'd0, r_p2[53:12]} + 55'd524288;
    assign mag    = t_sum[54:20];

    always_ff @(posedge i_clk) begin
        case (i_cmd.kstep)
            K_TERM: r_term <= ang_c * $signed({1'b0, i_cfg.half_track});
            K_SUM: begin
                r_dm   <= d_abs[41:0];
                r_dneg <= d_sum[43];
            end
            K_MUL: begin
                r_p1 <= r_dm * i_cfg.rpm_gain[23:12];
                r_p2 <= r_dm * i_cfg.rpm_gain[11:0];
            end
            K_MAG: begin
                r_mag <= mag;
                r_neg <= r_dneg && mag != 35'd0;
            end
            K_ZERO: begin
                r_mag <= 35'd0;
                r_neg <= 1'b0;
            end
            default: ;
        endcase
    end

    // duty = mag*255/max_speed, restoring division one bit a cycle
    logic [22:0] r_dnum;
    logic [14:0] r_rem;
    logic [15:0] rem2;
    logic [7:0]  r_q;
    logic [4:0]  r_dcnt;
    logic        qbit;

    assign rem2 = {r_rem, r_dnum[22]};
    assign qbit = rem2 >= {1'b0, i_cfg.max_speed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= 5'd0;
        end else if (i_cmd.div_start) begin
            r_dcnt <= 5'd23;
        end else if (r_dcnt != 5'd0) begin
            r_dcnt <= r_dcnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dnum <= {r_mag[14:0], 8'd0} - {8'd0, r_mag[14:0]};
            r_rem  <= 15'd0;
            r_q    <= 8'd0;
        end else if (r_dcnt != 5'd0) begin
            r_dnum <= {r_dnum[21:0], 1'b0};
            r_rem  <= qbit ? 15'(rem2 - {1'b0, i_cfg.max_speed}) : rem2[14:0];
            r_q    <= {r_q[6:0], qbit};
        end
    end

    // result register
    logic [15:0] vel;
    logic        over, alert_m;
    t_res        res_n, r_res;

    assign vel = r_neg ? (r_mag > 35'd32768 ? 16'h8000 : 16'd0 - r_mag[15:0])
                       : (r_mag > 35'd32767 ? 16'h7FFF : r_mag[15:0]);
    assign over    = r_mag >= {20'd0, i_cfg.max_speed};
    assign alert_m = r_alert[i_cmd.motor];

    always_comb begin
        res_n = '0;
        res_n.last = i_cmd.last;
        case (i_cmd.osel)
            OSEL_LINE: begin
                res_n.motor_index = r_cls_motor;
                res_n.action      = r_cls_act;
                res_n.status      = r_cls_st;
            end
            OSEL_WHEEL: begin
                res_n.motor_index = i_cmd.motor;
                res_n.velocity    = vel;
                if (over) begin
                    res_n.status = ST_LIMIT;
                end else if (alert_m) begin
                    res_n.status = ST_ALERT;
                end else begin
                    res_n.action          = ACT_SETVEL;
                    res_n.direction_level = r_neg ^ i_cfg.dir_inv[i_cmd.motor];
                    res_n.duty            = r_q;
                end
            end
            default: begin
                res_n.motor_index = i_cmd.motor;
                res_n.action      = i_cmd.act;
                res_n.status      = i_cmd.st;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_res <= res_n;
    end

    assign o_res = r_res;
    assign o_sts = '{cls: r_cls, div_done: r_dcnt == 5'd0, en: r_en};

endmodule

// ----- hdl/sdcd_ctrl.sv -----
module sdcd_ctrl
    import sdcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_kind i_kind,
    input  logic [7:0] i_rx_byte,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CLS, S_LINE, S_KTERM, S_KSUM, S_KMUL, S_KMAG, S_DIVGO,
        S_DIVW, S_WHEEL, S_LZERO, S_LDIS, S_EVENT, S_CLR
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_m, n_m;
    logic       r_plus, n_plus;
    logic       r_link, n_link;
    logic       r_ovalid, n_ovalid;
    logic       in_fire, out_free;
    logic [3:0] above;

    assign in_fire  = i_in_valid && r_state == S_IDLE;
    assign out_free = !r_ovalid || i_out_ready;
    assign above    = 4'(4'b1110 << r_m);

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state = r_state; n_m = r_m; n_plus = r_plus; n_link = r_link;
        o_cmd = '0;
        o_cmd.take  = in_fire;
        o_cmd.plus  = r_plus;
        o_cmd.motor = r_m;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_kind)
                        KIND_BYTE:   if (i_rx_byte == CH_LF) n_state = S_CLS;
                        KIND_STATUS: begin n_m = 2'd0; n_state = S_EVENT; end
                        KIND_LINK:   n_state = S_LZERO;
                        default: ;
                    endcase
                end
            end
            S_CLS: begin
                unique case (i_sts.cls)
                    CLS_ONE: n_state = S_LINE;
                    CLS_VEL: begin
                        n_plus = 1'b1; n_link = 1'b0; n_m = 2'd0; n_state = S_KTERM;
                    end
                    default: n_state = S_CLR;
                endcase
            end
            S_LINE: begin
                if (out_free) begin
                    o_cmd.load = 1'b1; o_cmd.osel = OSEL_LINE; o_cmd.last = 1'b1;
                    n_state = S_CLR;
                end
            end
            S_KTERM: begin o_cmd.kstep = K_TERM; n_state = S_KSUM; end
            S_KSUM:  begin o_cmd.kstep = K_SUM;  n_state = S_KMUL; end
            S_KMUL:  begin o_cmd.kstep = K_MUL;  n_state = S_KMAG; end
            S_KMAG:  begin o_cmd.kstep = K_MAG;  n_state = S_DIVGO; end
            S_LZERO: begin
                o_cmd.kstep = K_ZERO; n_link = 1'b1; n_m = 2'd0; n_state = S_DIVGO;
            end
            S_DIVGO: begin o_cmd.div_start = 1'b1; n_state = S_DIVW; end
            S_DIVW:  if (i_sts.div_done) n_state = S_WHEEL;
            S_WHEEL: begin
                if (out_free) begin
                    o_cmd.load = 1'b1; o_cmd.osel = OSEL_WHEEL;
                    o_cmd.last = !r_link && r_m == 2'd3;
                    n_m = r_m + 2'd1;
                    if (r_m == 2'd3) begin
                        n_state = r_link ? S_LDIS : S_CLR;
                    end else if (!r_link && r_m == 2'd1) begin
                        n_plus = 1'b0; n_state = S_KTERM;
                    end
                end
            end
            S_LDIS: begin
                if (out_free) begin
                    o_cmd.load = 1'b1; o_cmd.osel = OSEL_CODE;
                    o_cmd.act = ACT_DISABLE; o_cmd.st = ST_OK;
                    o_cmd.last = r_m == 2'd3;
                    n_m = r_m + 2'd1;
                    if (r_m == 2'd3) n_state = S_IDLE;
                end
            end
            S_EVENT: begin
                if (i_sts.en[r_m] || out_free) begin
                    if (!i_sts.en[r_m]) begin
                        o_cmd.load = 1'b1; o_cmd.osel = OSEL_CODE;
                        o_cmd.act = ACT_RESET; o_cmd.st = ST_UNEXP_DIS;
                        o_cmd.last = (~i_sts.en & above) == 4'd0;
                    end
                    n_m = r_m + 2'd1;
                    if (r_m == 2'd3) n_state = S_IDLE;
                end
            end
            S_CLR: begin o_cmd.clear = 1'b1; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
        n_ovalid = o_cmd.load ? 1'b1 : (i_out_ready ? 1'b0 : r_ovalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_m <= 2'd0; r_plus <= 1'b1; r_link <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_m <= n_m; r_plus <= n_plus; r_link <= n_link;
            r_ovalid <= n_ovalid;
        end
    end

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> out_free) else $error("result loaded over a waiting one");
    a_link_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_kind == KIND_LINK) |=> r_state == S_LZERO)
        else $error("link loss not started");
    a_div_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVGO) |=> !i_sts.div_done) else $error("divider did not start");
`endif

endmodule

// ----- hdl/serial_drive_command_decoder.sv -----
// Serial command decoder for a four-motor differential drive.
// Input channel (i_in): one item per serial character, motor status update or
// link-loss event. Output channel (o_out): motor commands and status reports,
// 'last' marks the final result of an item. APB port sets the speed limit,
// direction inversion, half track and rpm gain.
// Flow: a character that does not end a line is taken in the idle state and the
// next item may follow immediately. An LF is first classified; an empty line
// then clears the line state, and a 'd'/'e'/error line loads its result once
// the result register is free. A 'v' line runs the kinematics twice (four steps
// each, one multiply level per step) and a 23-step bit-serial duty divider per
// side, then loads one result per wheel. A status update checks each motor in
// turn; link loss zeroes the speeds, runs the divider once, loads eight results.
// Reset: line state cleared, alert mask clear, registers to their defaults.
// Output stall: one result register holds the waiting item; the sequencer
// waits on it before loading the next result, and a new item is taken once
// the last result of the current one has been loaded, even while it waits.
module serial_drive_command_decoder
    import sdcd_pkg::*;
#(
    parameter int LINE_LIMIT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdcd_in_if.sink     i_in,
    sdcd_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;
    t_res res;

    sdcd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: handshakes and result order
    sdcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_kind      (t_kind'(i_in.kind)),
        .i_rx_byte   (i_in.rx_byte),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // parser, kinematics, divider and result register
    sdcd_dp #(.LINE_LIMIT(LINE_LIMIT)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .i_kind          (t_kind'(i_in.kind)),
        .i_rx_byte       (i_in.rx_byte),
        .i_alert_flags   (i_in.alert_flags),
        .i_enabled_flags (i_in.enabled_flags),
        .o_sts           (sts),
        .o_res           (res)
    );

    assign o_out.motor_index     = res.motor_index;
    assign o_out.action          = res.action;
    assign o_out.direction_level = res.direction_level;
    assign o_out.duty            = res.duty;
    assign o_out.velocity        = $signed(res.velocity);
    assign o_out.status          = res.status;
    assign o_out.last            = res.last;

endmodule

// ----- tb/sdcd_checker.sv -----
module sdcd_checker
    import sdcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdcd_in_if          in_ch,
    sdcd_out_if         out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        PH_IDLE, PH_WS1, PH_SIGN1, PH_DIG1, PH_WS2, PH_SIGN2, PH_DIG2,
        PH_DONE, PH_FAIL, PH_MFIRST, PH_MDIG
    } t_phase;

    localparam int LINE_LIMIT = 64;

    // register shadow
    logic [14:0] max_speed;
    logic [3:0]  dir_inv;
    logic [17:0] half_track;
    logic [23:0] rpm_gain;

    // line assembly state
    int unsigned line_len;
    logic        ovf;
    logic [7:0]  letter;
    t_phase      phase;
    int unsigned motor_no;
    int unsigned lin_mag, ang_mag;
    logic [1:0]  neg_flags;
    logic [3:0]  alert_mask;

    t_res expected_cmds[$];
    int   n_out;

    function automatic int unsigned accum(int unsigned v, logic [7:0] c);
        int unsigned n;
        n = v * 10 + (c - 8'd48);
        return (v > MAG_MAX / 10 || n > MAG_MAX) ? MAG_MAX : n;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic void push_cmd(int m, t_action a, logic dir, logic [7:0] duty,
                                     logic [15:0] vel, t_status st);
        t_res r;
        r.motor_index = m[1:0];
        r.action = a;
        r.direction_level = dir;
        r.duty = duty;
        r.velocity = vel;
        r.status = st;
        r.last = 1'b0;
        expected_cmds.push_back(r);
        n_out++;
    endfunction

    function automatic void clear_line();
        line_len = 0; ovf = 0; letter = 0; phase = PH_IDLE;
        motor_no = 0; lin_mag = 0; ang_mag = 0; neg_flags = 0;
    endfunction

    // exact rpm of one side: right is linear plus turn term
    function automatic void side_rpm(bit plus, output bit neg,
                                     output longint unsigned mag);
        longint lin, ang, ht, d;
        longint unsigned dm;
        logic [127:0] prod;
        lin = neg_flags[0] ? -longint'(lin_mag) : longint'(lin_mag);
        ang = neg_flags[1] ? -longint'(ang_mag) : longint'(ang_mag);
        ht = half_track;
        d = plus ? lin * 65536 + ang * ht : lin * 65536 - ang * ht;
        dm = d < 0 ? -d : d;
        prod = 128'(dm) * 128'(rpm_gain);
        prod = ((prod >> 12) + (128'd1 << 19)) >> 20;
        mag = prod[63:0];
        neg = d < 0 && mag != 0;
    endfunction

    function automatic void wheel_cmd(int m, bit neg, longint unsigned mag);
        logic [15:0] vel;
        longint unsigned duty;
        if (neg) vel = 16'(32'h10000 - (mag > 32768 ? 32768 : mag));
        else vel = mag > 32767 ? 16'd32767 : 16'(mag);
        if (mag >= max_speed) begin
            push_cmd(m, ACT_REPORT, 0, 0, vel, ST_LIMIT);
        end else if (alert_mask[m]) begin
            push_cmd(m, ACT_REPORT, 0, 0, vel, ST_ALERT);
        end else begin
            duty = mag * 255 / max_speed;
            push_cmd(m, ACT_SETVEL, neg ^ dir_inv[m], duty[7:0], vel, ST_OK);
        end
    endfunction

    function automatic void settle();
        if (phase == PH_DIG2 || phase == PH_MDIG) phase = PH_DONE;
        else if (phase != PH_DONE) phase = PH_FAIL;
    endfunction

    function automatic void parse_char(logic [7:0] c);
        logic [7:0] l;
        int unsigned n;
        if (line_len == 0) begin
            l = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
            letter = l;
            phase = (c == 0) ? PH_FAIL : (l == "v" ? PH_WS1 : PH_MFIRST);
            return;
        end
        if (phase inside {PH_DONE, PH_FAIL, PH_IDLE}) return;
        if (c == 0) begin
            settle();
            return;
        end
        case (phase)
            PH_WS1, PH_WS2: begin
                if (!is_blank(c)) begin
                    if (c == "+" || c == "-") begin
                        if (c == "-") neg_flags |= (phase == PH_WS2) ? 2'b10 : 2'b01;
                        phase = (phase == PH_WS2) ? PH_SIGN2 : PH_SIGN1;
                    end else if (is_digit(c)) begin
                        if (phase == PH_WS2) begin
                            ang_mag = accum(ang_mag, c); phase = PH_DIG2;
                        end else begin
                            lin_mag = accum(lin_mag, c); phase = PH_DIG1;
                        end
                    end else phase = PH_FAIL;
                end
            end
            PH_SIGN1: begin
                if (is_digit(c)) begin
                    lin_mag = accum(lin_mag, c); phase = PH_DIG1;
                end else phase = PH_FAIL;
            end
            PH_SIGN2: begin
                if (is_digit(c)) begin
                    ang_mag = accum(ang_mag, c); phase = PH_DIG2;
                end else phase = PH_FAIL;
            end
            PH_DIG1: begin
                if (is_digit(c)) lin_mag = accum(lin_mag, c);
                else if (is_blank(c)) phase = PH_WS2;
                else if (c == "+" || c == "-") begin
                    if (c == "-") neg_flags |= 2'b10;
                    phase = PH_SIGN2;
                end else phase = PH_FAIL;
            end
            PH_DIG2: begin
                if (is_digit(c)) ang_mag = accum(ang_mag, c);
                else phase = PH_DONE;
            end
            PH_MFIRST, PH_MDIG: begin
                if (is_digit(c)) begin
                    n = motor_no * 10 + (c - 8'd48);
                    motor_no = (motor_no > 3 || n > 3) ? 4 : n;
                    phase = PH_MDIG;
                end else phase = (phase == PH_MDIG) ? PH_DONE : PH_FAIL;
            end
            default: phase = PH_FAIL;
        endcase
    endfunction

    function automatic void close_line();
        bit rn, ln;
        longint unsigned rm, lm;
        if (ovf) begin
            push_cmd(0, ACT_REPORT, 0, 0, 0, ST_OVERRUN);
            return;
        end
        if (line_len == 0) return;
        settle();
        if (letter < "a" || letter > "z") begin
            push_cmd(0, ACT_REPORT, 0, 0, 0, ST_BAD_LETTER);
        end else if (letter == "v") begin
            if (phase != PH_DONE) begin
                push_cmd(0, ACT_REPORT, 0, 0, 0, ST_BAD_PARAMS);
            end else begin
                side_rpm(1, rn, rm);
                side_rpm(0, ln, lm);
                wheel_cmd(0, rn, rm);
                wheel_cmd(1, rn, rm);
                wheel_cmd(2, ln, lm);
                wheel_cmd(3, ln, lm);
            end
        end else if (phase != PH_DONE || motor_no > 3) begin
            push_cmd(0, ACT_REPORT, 0, 0, 0, ST_BAD_MOTOR);
        end else if (letter == "d") begin
            push_cmd(motor_no, ACT_DISABLE, 0, 0, 0, ST_OK);
        end else if (letter == "e") begin
            push_cmd(motor_no, ACT_ENABLE, 0, 0, 0, ST_OK);
        end else begin
            push_cmd(0, ACT_REPORT, 0, 0, 0, ST_UNKNOWN);
        end
    endfunction

    function automatic void predict_item(t_kind k, logic [7:0] c, logic [3:0] al,
                                         logic [3:0] en);
        n_out = 0;
        case (k)
            KIND_BYTE: begin
                if (c == CH_LF) begin
                    close_line();
                    clear_line();
                end else if (c != CH_CR) begin
                    if (line_len < LINE_LIMIT) begin
                        parse_char(c);
                        line_len++;
                    end else ovf = 1;
                end
            end
            KIND_STATUS: begin
                alert_mask = al;
                for (int i = 0; i < MOTOR_COUNT; i++)
                    if (!en[i]) push_cmd(i, ACT_RESET, 0, 0, 0, ST_UNEXP_DIS);
            end
            KIND_LINK: begin
                for (int i = 0; i < MOTOR_COUNT; i++) wheel_cmd(i, 0, 0);
                for (int i = 0; i < MOTOR_COUNT; i++)
                    push_cmd(i, ACT_DISABLE, 0, 0, 0, ST_OK);
            end
            default: ;
        endcase
        if (n_out > 0) expected_cmds[expected_cmds.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            max_speed <= 15'd1000;
            dir_inv <= 4'd3;
            half_track <= 18'd19661;
            rpm_gain <= 24'd4172;
            alert_mask = 0;
            clear_line();
            expected_cmds.delete();
            o_fail_count <= 0;
            o_results <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg'(paddr[3:2]))
                    REG_MAX_SPEED:  max_speed <= pwdata[14:0];
                    REG_DIR_INV:    dir_inv <= pwdata[3:0];
                    REG_HALF_TRACK: half_track <= pwdata[17:0];
                    REG_RPM_GAIN:   rpm_gain <= pwdata[23:0];
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got.motor_index = out_ch.motor_index;
                got.action = t_action'(out_ch.action);
                got.direction_level = out_ch.direction_level;
                got.duty = out_ch.duty;
                got.velocity = out_ch.velocity;
                got.status = t_status'(out_ch.status);
                got.last = out_ch.last;
                o_results <= o_results + 1;
                if (expected_cmds.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%t: unexpected result %p", $realtime, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.motor_index !== want.motor_index || got.action !== want.action
                        || got.direction_level !== want.direction_level
                        || got.duty !== want.duty || got.velocity !== want.velocity
                        || got.status !== want.status || got.last !== want.last) begin
                        if (o_fail_count < 10)
                            $display("%t: mismatch\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // register writes land at this edge; items here still see old values
            if (in_ch.valid && in_ch.ready)
                predict_item(t_kind'(in_ch.kind), in_ch.rx_byte, in_ch.alert_flags,
                             in_ch.enabled_flags);
        end
        o_pending = expected_cmds.size();
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    import sdcd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 56;
    localparam int DRAIN_CYCLES = 120;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int  fail_count, pending, results;
    int  items_sent;
    int  cycles;
    bit  calm;          // no idling on either side once set

    byte unsigned line_buf[$];

    sdcd_in_if  in_ch();
    sdcd_out_if out_ch();

    serial_drive_command_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sdcd_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side back-pressure: random stall bursts, none when calm
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    // one item on the input channel; called and returns at a falling edge
    task automatic send_item(t_kind k, logic [7:0] c);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        in_ch.kind = k;
        in_ch.rx_byte = c;
        in_ch.alert_flags = $urandom_range(0, 15);
        in_ch.enabled_flags = $urandom_range(0, 15);
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_status(logic [3:0] al, logic [3:0] en);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        in_ch.kind = KIND_STATUS;
        in_ch.rx_byte = $urandom_range(0, 255);
        in_ch.alert_flags = al;
        in_ch.enabled_flags = en;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic void add_text(string s);
        foreach (s[i]) line_buf.push_back(s[i]);
    endfunction

    // sends the buffer then LF
    task automatic send_line();
        foreach (line_buf[i]) send_item(KIND_BYTE, line_buf[i]);
        send_item(KIND_BYTE, CH_LF);
        line_buf.delete();
    endtask

    task automatic text_line(string s);
        add_text(s);
        send_line();
    endtask

    task automatic reg_write(t_reg r, logic [31:0] v);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {r, 2'b00};
        pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // quiet point: every expected result out, then room for a line end
    // still in the kinematics that has nothing left to emit
    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] ms, logic [31:0] di, logic [31:0] ht,
                            logic [31:0] g);
        wait_idle();
        reg_write(REG_MAX_SPEED, ms);
        reg_write(REG_DIR_INV, di);
        reg_write(REG_HALF_TRACK, ht);
        reg_write(REG_RPM_GAIN, g);
    endtask

    function automatic byte unsigned blank_char();
        case ($urandom_range(0, 3))
            0: return 8'd32;
            1: return 8'd9;
            2: return 8'd11;
            default: return 8'd12;
        endcase
    endfunction

    function automatic string number_text();
        case ($urandom_range(0, 9))
            0: return $sformatf("%0d", $urandom_range(0, 99999999));
            1: return "0";
            2, 3: return $sformatf("%0d", $urandom_range(0, 30000));
            default: return $sformatf("%0d", $urandom_range(0, 600));
        endcase
    endfunction

    // well-formed speed line with random spacing, signs and case
    task automatic speed_line();
        add_text($urandom_range(0, 3) == 0 ? "V" : "v");
        repeat ($urandom_range(0, 2)) line_buf.push_back(blank_char());
        case ($urandom_range(0, 2))
            0: add_text("-");
            1: add_text("+");
            default: ;
        endcase
        add_text(number_text());
        if ($urandom_range(0, 3) == 0) begin
            add_text($urandom_range(0, 1) ? "-" : "+");
        end else begin
            line_buf.push_back(blank_char());
            case ($urandom_range(0, 2))
                0: add_text("-");
                1: add_text("+");
                default: ;
            endcase
        end
        add_text(number_text());
        if ($urandom_range(0, 4) == 0) add_text(" junk");
        if ($urandom_range(0, 5) == 0) send_item(KIND_BYTE, CH_CR);
        send_line();
    endtask

    task automatic random_phase(int n_items);
        int goal;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3, 4: speed_line();
                5, 6: begin
                    add_text($urandom_range(0, 1) ? "d" : "E");
                    if ($urandom_range(0, 5) != 0)
                        add_text($sformatf("%0d", $urandom_range(0, 3)));
                    else
                        add_text($sformatf("%0d", $urandom_range(0, 120)));
                    send_line();
                end
                7: begin
                    repeat ($urandom_range(1, 6))
                        line_buf.push_back($urandom_range(0, 255));
                    send_line();
                end
                8: send_status($urandom_range(0, 15), $urandom_range(0, 15));
                9: send_item(KIND_LINK, $urandom_range(0, 255));
                10: send_item(KIND_SPARE, $urandom_range(0, 255));
                default: begin
                    // broken speed lines
                    case ($urandom_range(0, 2))
                        0: text_line("v 12");
                        1: text_line("v - 4 5");
                        default: text_line("v3x 4");
                    endcase
                end
            endcase
        end
    endtask

    initial begin
        calm = 1'b0;
        items_sent = 0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_BYTE;
        in_ch.rx_byte = 8'd0;
        in_ch.alert_flags = 4'd0;
        in_ch.enabled_flags = 4'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 4'd0;
        pwdata = 32'd0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed lines at reset settings
        text_line("v 100 -50");
        text_line("V-20+30");
        text_line("d2");
        text_line("e0");
        text_line("d7");           // motor out of range
        text_line("d");            // no motor digit
        text_line("x1");           // unknown letter
        text_line("!");            // not a letter
        text_line("v1");           // missing second number
        send_item(KIND_BYTE, CH_LF);               // empty line
        send_item(KIND_BYTE, CH_CR);
        add_text("v5 5");
        line_buf.push_back(8'd0);                 // NUL ends parsed text
        add_text("zz");
        send_line();
        line_buf.push_back(8'd0);
        send_line();
        repeat (70) line_buf.push_back("a");       // overrun
        send_line();
        text_line("v 99999999 99999999");
        send_status(4'b0101, 4'b0110);
        text_line("v 200 0");      // alerted wheels rejected
        send_status(4'b0000, 4'b1111);
        add_text("v 30");
        send_item(KIND_BYTE, "v");
        line_buf.delete();
        send_item(KIND_LINK, 8'hFF);              // link loss mid-line
        text_line(" 40");
        send_item(KIND_SPARE, 8'h00);

        random_phase(RANDOM_ITEMS / 4);

        // top of every register range
        set_regs(32'd32767, 32'd15, 32'd262143, 32'd16777215);
        text_line("v 1 1");
        random_phase(RANDOM_ITEMS / 4);

        // bottom of every register range but max speed, which is set to one
        set_regs(32'd1, 32'd0, 32'd0, 32'd0);
        text_line("v 0 0");
        random_phase(RANDOM_ITEMS / 4);

        // random mid settings, last stretch without idling
        set_regs($urandom_range(200, 5000), $urandom_range(0, 15),
                 $urandom_range(0, 262143), $urandom_range(1000, 200000));
        calm = 1'b1;
        random_phase(RANDOM_ITEMS / 4);

        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d input items and %0d results over four register settings",
                 items_sent, results);
        $display("with speed, enable/disable, malformed, overrun, status and link-loss items");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- serial_drive_command_decoder.f -----
hdl/sdcd_pkg.sv
hdl/sdcd_if.sv
hdl/sdcd_cfg.sv
hdl/sdcd_dp.sv
hdl/sdcd_ctrl.sv
hdl/serial_drive_command_decoder.sv
tb/sdcd_checker.sv
tb/tb.sv
